// ----- sv/bir_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bir_pkg;
    localparam int MAX_DIM = 256;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = IDX_W + 1;
    localparam int SCALE_W = 24;
    localparam int POS_W = IDX_W + SCALE_W;
    localparam int DELTA_W = FRAC_BITS + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } bir_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } bir_out_t;
endpackage
`default_nettype wire

// ----- sv/bilinear_image_resize_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bilinear image resize unit.
// s_ channel: one transaction per cycle while s_ready is high. action=load writes one RGB source
// pixel at (row, col) of a 256x256 frame store; action=request asks for
// destination pixel (row, col) of the resized image.
// m_ channel: one transaction per request, in request order; loads give none.
// cfg port: cfg_we writes cfg_data into register cfg_index (0 src_width,
// 1 src_height, 2 col_scale, 3 row_scale); the user must write them only while
// the unit is idle; the unit itself does not enforce this.
// Throughput: one transaction per cycle while s_ready is high; the frame store is
// split into four banks by row and column parity so the four neighbours are read together.
// The pipeline: position multiply, clamp/delta, weight multiply with bank
// read, channel products, channel sum, saturate.
// A stall of m_ready freezes the whole pipeline; s_ready falls only while the
// final stage holds a result that is not taken. Nothing is lost or repeated.
// Reset clears configuration to 256x256 at scale 1.0 and empties the
// pipeline; the frame store is not cleared and must be loaded before use.
module bilinear_image_resize_unit
    import bir_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bir_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bir_out_t                   m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int HALF_W = IDX_W - 1;
    localparam int WGT_W = 2 * DELTA_W + 1;
    localparam int PROD_W = WGT_W + 9;
    localparam int SUM_W = PROD_W + 2;
    localparam int BANK_DEPTH = MAX_DIM * MAX_DIM / 4;
    localparam int BA_W = 2 * HALF_W;
    localparam logic [DELTA_W:0] ONE_FX = (DELTA_W+1)'(1) << FRAC_BITS;
    localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

    logic [DIM_W-1:0]   src_width_reg, src_height_reg;
    logic [SCALE_W-1:0] col_scale_reg, row_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(MAX_DIM);
            src_height_reg <= DIM_W'(MAX_DIM);
            col_scale_reg  <= SCALE_W'(1 << FRAC_BITS);
            row_scale_reg  <= SCALE_W'(1 << FRAC_BITS);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[DIM_W-1:0];
                REG_COL_SCALE:  col_scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_ROW_SCALE:  row_scale_reg  <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [IDX_W-1:0] lim_of(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        c = (d < DIM_W'(2)) ? DIM_W'(2) : ((d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d);
        return IDX_W'(c - DIM_W'(2));
    endfunction

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    assign adv = !v6_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = v6_reg;

    // stage 1: position
    logic [POS_W-1:0] rpos1_reg, cpos1_reg;
    logic [IDX_W-1:0] rlim1_reg, clim1_reg;
    // load write, retired on an advancing edge so it stays ordered with reads
    logic             we_reg;
    logic [IDX_W-1:0] wr_row_reg, wr_col_reg;
    logic [23:0]      wpx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            we_reg <= 1'b0;
        end else if (adv) begin
            we_reg <= s_valid && s_data.action == ACT_LOAD;
            v1_reg <= s_valid && s_data.action == ACT_REQUEST;
        end
        if (adv) begin
            wr_row_reg <= s_data.row;
            wr_col_reg <= s_data.col;
            wpx_reg <= {s_data.blue_in, s_data.green_in, s_data.red_in};
            rpos1_reg <= POS_W'(s_data.row * row_scale_reg);
            cpos1_reg <= POS_W'(s_data.col * col_scale_reg);
            rlim1_reg <= lim_of(src_height_reg);
            clim1_reg <= lim_of(src_width_reg);
        end
    end

    // stage 2: clamp and delta
    logic [IDX_W-1:0]   rb2_reg, cb2_reg;
    logic [DELTA_W-1:0] dr2_reg, dc2_reg;

    function automatic logic [IDX_W+DELTA_W-1:0] locate(input logic [POS_W-1:0] p,
                                                       input logic [IDX_W-1:0] lim);
        logic [POS_W-FRAC_BITS-1:0] ip;
        logic [IDX_W-1:0] b;
        logic [POS_W-1:0] d;
        ip = p[POS_W-1:FRAC_BITS];
        b = (ip > (POS_W-FRAC_BITS)'(lim)) ? lim : IDX_W'(ip);
        d = p - ({(POS_W-IDX_W)'(0), b} << FRAC_BITS);
        return {b, (d > POS_W'(DELTA_MAX)) ? DELTA_MAX : DELTA_W'(d)};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            {rb2_reg, dr2_reg} <= locate(rpos1_reg, rlim1_reg);
            {cb2_reg, dc2_reg} <= locate(cpos1_reg, clim1_reg);
        end
    end

    // stage 3: weights and bank read
    logic signed [WGT_W-1:0] w1_reg, w2_reg, w3_reg, w4_reg;
    logic signed [DELTA_W+1:0] odr, odc, sdr, sdc;
    assign odr = $signed({1'b0, ONE_FX}) - $signed({2'b0, dr2_reg});
    assign odc = $signed({1'b0, ONE_FX}) - $signed({2'b0, dc2_reg});
    assign sdr = $signed({2'b0, dr2_reg});
    assign sdc = $signed({2'b0, dc2_reg});

    logic [IDX_W-1:0] r1, c1;
    assign r1 = rb2_reg + IDX_W'(1);
    assign c1 = cb2_reg + IDX_W'(1);

    // bank[rp][cp]: rp/cp = row/col parity
    logic [23:0] bank00 [BANK_DEPTH];
    logic [23:0] bank01 [BANK_DEPTH];
    logic [23:0] bank10 [BANK_DEPTH];
    logic [23:0] bank11 [BANK_DEPTH];
    logic [23:0] q00_reg, q01_reg, q10_reg, q11_reg;
    logic [BA_W-1:0] wa;
    logic [HALF_W-1:0] re0, re1, ce0, ce1;
    logic rpar_reg, cpar_reg;
    assign wa = {wr_row_reg[IDX_W-1:1], wr_col_reg[IDX_W-1:1]};
    // even row/col index of the neighbour pair
    assign re0 = rb2_reg[0] ? r1[IDX_W-1:1] : rb2_reg[IDX_W-1:1];
    assign re1 = rb2_reg[0] ? rb2_reg[IDX_W-1:1] : r1[IDX_W-1:1];
    assign ce0 = cb2_reg[0] ? c1[IDX_W-1:1] : cb2_reg[IDX_W-1:1];
    assign ce1 = cb2_reg[0] ? cb2_reg[IDX_W-1:1] : c1[IDX_W-1:1];

    always_ff @(posedge aclk) begin
        if (we_reg && adv) begin
            unique case ({wr_row_reg[0], wr_col_reg[0]})
                2'b00: bank00[wa] <= wpx_reg;
                2'b01: bank01[wa] <= wpx_reg;
                2'b10: bank10[wa] <= wpx_reg;
                default: bank11[wa] <= wpx_reg;
            endcase
        end
        if (adv) begin
            q00_reg <= bank00[{re0, ce0}];
            q01_reg <= bank01[{re0, ce1}];
            q10_reg <= bank10[{re1, ce0}];
            q11_reg <= bank11[{re1, ce1}];
            rpar_reg <= rb2_reg[0];
            cpar_reg <= cb2_reg[0];
            w1_reg <= WGT_W'(odr * odc);
            w2_reg <= WGT_W'(sdr * odc);
            w3_reg <= WGT_W'(odr * sdc);
            w4_reg <= WGT_W'(sdr * sdc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end

    // stage 4: per-channel products
    logic [23:0] p00, p01, p10, p11;
    always_comb begin
        unique case ({rpar_reg, cpar_reg})
            2'b00: begin p00 = q00_reg; p01 = q01_reg; p10 = q10_reg; p11 = q11_reg; end
            2'b01: begin p00 = q01_reg; p01 = q00_reg; p10 = q11_reg; p11 = q10_reg; end
            2'b10: begin p00 = q10_reg; p01 = q11_reg; p10 = q00_reg; p11 = q01_reg; end
            default: begin p00 = q11_reg; p01 = q10_reg; p10 = q01_reg; p11 = q00_reg; end
        endcase
    end

    logic signed [PROD_W-1:0] m_reg [3][4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                m_reg[ch][0] <= PROD_W'($signed({1'b0, p00[8*ch +: 8]}) * w1_reg);
                m_reg[ch][1] <= PROD_W'($signed({1'b0, p10[8*ch +: 8]}) * w2_reg);
                m_reg[ch][2] <= PROD_W'($signed({1'b0, p01[8*ch +: 8]}) * w3_reg);
                m_reg[ch][3] <= PROD_W'($signed({1'b0, p11[8*ch +: 8]}) * w4_reg);
            end
        end
    end

    // stage 5: sum
    logic signed [SUM_W-1:0] s_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                s_reg[ch] <= SUM_W'(m_reg[ch][0]) + SUM_W'(m_reg[ch][1])
                           + SUM_W'(m_reg[ch][2]) + SUM_W'(m_reg[ch][3]);
            end
        end
    end

    // stage 6: saturate
    function automatic logic [7:0] fin(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        v = $unsigned(s) >> (2 * FRAC_BITS);
        if (s <= 0) return 8'd0;
        return (v > SUM_W'(255)) ? 8'd255 : v[7:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
        if (adv) begin
            m_data.red_out   <= fin(s_reg[0]);
            m_data.green_out <= fin(s_reg[1]);
            m_data.blue_out  <= fin(s_reg[2]);
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready mismatch");
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_LOAD |=> !v1_reg)
        else $error("load produced work");
endmodule
`default_nettype wire

// ----- bench/bilinear_image_resize_unit_test.sv -----
`timescale 1ns / 1ps
module bilinear_image_resize_unit_test;
    import bir_pkg::*;

    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam longint DELTA_LIMIT = (longint'(4) << FRAC_BITS) - 1;
    localparam int QUIET_LIMIT = 4000;

    class resize_scoreboard;
        logic [23:0] frame[int];
        int unsigned width_reg, height_reg, col_scale_reg, row_scale_reg;
        bir_out_t pixel_q[$];
        int errors;

        function new();
            width_reg = 256;
            height_reg = 256;
            col_scale_reg = 65536;
            row_scale_reg = 65536;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_SRC_WIDTH: width_reg = v[8:0];
                REG_SRC_HEIGHT: height_reg = v[8:0];
                REG_COL_SCALE: col_scale_reg = v;
                REG_ROW_SCALE: row_scale_reg = v;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_size(int unsigned d);
            if (d < 2) return 2;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        function void locate(int unsigned idx, int unsigned scale, int unsigned d,
                             output int unsigned base, output longint delta);
            longint pos, ip, lim;
            pos = longint'(idx) * longint'(scale);
            ip = pos >>> FRAC_BITS;
            lim = longint'(clamp_size(d)) - 2;
            if (ip > lim) ip = lim;
            base = int'(ip);
            delta = pos - (ip <<< FRAC_BITS);
            if (delta > DELTA_LIMIT) delta = DELTA_LIMIT;
        endfunction

        function bit covered(logic [7:0] row, logic [7:0] col);
            int unsigned rb, cb, a;
            longint dr, dc;
            locate(row, row_scale_reg, height_reg, rb, dr);
            locate(col, col_scale_reg, width_reg, cb, dc);
            a = rb * MAX_DIM + cb;
            return frame.exists(a) && frame.exists(a + 1) &&
                   frame.exists(a + MAX_DIM) && frame.exists(a + MAX_DIM + 1);
        endfunction

        function logic [7:0] saturate(longint sum);
            longint v;
            if (sum <= 0) return 8'd0;
            v = sum >>> (2 * FRAC_BITS);
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function void note_input(bir_in_t x);
            int unsigned rb, cb, a;
            longint dr, dc, w1, w2, w3, w4, sum;
            logic [23:0] p00, p01, p10, p11;
            logic [7:0] ch[3];
            if (x.action == ACT_LOAD) begin
                frame[x.row * MAX_DIM + x.col] = {x.blue_in, x.green_in, x.red_in};
                return;
            end
            locate(x.row, row_scale_reg, height_reg, rb, dr);
            locate(x.col, col_scale_reg, width_reg, cb, dc);
            w1 = (ONE_Q - dr) * (ONE_Q - dc);
            w2 = dr * (ONE_Q - dc);
            w3 = (ONE_Q - dr) * dc;
            w4 = dr * dc;
            a = rb * MAX_DIM + cb;
            p00 = frame.exists(a) ? frame[a] : 24'd0;
            p01 = frame.exists(a + 1) ? frame[a + 1] : 24'd0;
            p10 = frame.exists(a + MAX_DIM) ? frame[a + MAX_DIM] : 24'd0;
            p11 = frame.exists(a + MAX_DIM + 1) ? frame[a + MAX_DIM + 1] : 24'd0;
            for (int c = 0; c < 3; c++) begin
                sum = longint'(p00[8*c +: 8]) * w1 + longint'(p10[8*c +: 8]) * w2
                    + longint'(p01[8*c +: 8]) * w3 + longint'(p11[8*c +: 8]) * w4;
                ch[c] = saturate(sum);
            end
            pixel_q.push_back('{red_out: ch[0], green_out: ch[1], blue_out: ch[2]});
        endfunction

        function void check_result(bir_out_t y);
            bir_out_t e;
            if (pixel_q.size() == 0) begin
                report($sformatf("unexpected pixel %h", y));
                return;
            end
            e = pixel_q.pop_front();
            if (y.red_out !== e.red_out)
                report($sformatf("red %0d, want %0d", y.red_out, e.red_out));
            if (y.green_out !== e.green_out)
                report($sformatf("green %0d, want %0d", y.green_out, e.green_out));
            if (y.blue_out !== e.blue_out)
                report($sformatf("blue %0d, want %0d", y.blue_out, e.blue_out));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bir_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bir_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    resize_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    bilinear_image_resize_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("bilinear_image_resize_unit_test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send(bir_in_t x);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_pixel(logic [7:0] row, logic [7:0] col);
        bir_in_t x;
        x = '{action: ACT_LOAD, row: row, col: col, red_in: 8'($urandom),
              green_in: 8'($urandom), blue_in: 8'($urandom)};
        send(x);
    endtask

    task automatic request_pixel(logic [7:0] row, logic [7:0] col);
        bir_in_t x;
        x = '{action: ACT_REQUEST, row: row, col: col, red_in: 8'($urandom),
              green_in: 8'($urandom), blue_in: 8'($urandom)};
        send(x);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pixel_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned cs, int unsigned rs);
        logic [CFG_DATA_W-1:0] vals[4];
        vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(cs), CFG_DATA_W'(rs)};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_scale();
        case ($urandom_range(5))
            0: return 1;
            1: return 65536;
            2: return $urandom_range(1 << 12, 1 << 18);
            3: return 24'h800000;
            4: return $urandom & 24'hFFFFFF;
            default: return $urandom_range(1 << 14, 1 << 17);
        endcase
    endfunction

    task automatic random_traffic(int count);
        logic [7:0] r, c;
        bit ok;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 25) begin
                load_pixel(8'($urandom), 8'($urandom));
            end else begin
                ok = 0;
                for (int t = 0; t < 40 && !ok; t++) begin
                    r = ($urandom_range(3) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom);
                    c = ($urandom_range(3) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom);
                    ok = sb.covered(r, c);
                end
                if (!ok) begin
                    r = 0;
                    c = 0;
                end
                request_pixel(r, c);
            end
        end
    endtask

    initial begin
        int unsigned w, h;
        bir_in_t x;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner pixels at default 256x256, unit scale
        for (int i = 0; i < 8; i++) begin
            x = '{action: ACT_LOAD, row: (i < 4) ? 8'(i[1]) : 8'(254 + i[1]),
                  col: (i < 4) ? 8'(i[0]) : 8'(254 + i[0]),
                  red_in: i[0] ? 8'd255 : 8'd0, green_in: i[1] ? 8'd255 : 8'd0,
                  blue_in: (i[2] ^ i[0]) ? 8'd255 : 8'd0};
            send(x);
        end
        request_pixel(0, 0);
        request_pixel(254, 254);
        request_pixel(255, 255);
        request_pixel(254, 255);
        request_pixel(255, 254);
        drain();

        for (int p = 0; p < 8; p++) begin
            send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 32 : 70) : 0;
            recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 32 : 70) : 0;
            case (p)
                0: configure(2, 2, 24'h800000, 24'h800000);
                1: configure(0, 1, 0, 0);
                2: configure(511, 300, 24'hFFFFFF, $urandom_range(1, 1 << 17));
                3: configure(256, 256, 65536, 65536);
                default: configure($urandom_range(2, 8), $urandom_range(2, 8),
                                   pick_scale(), pick_scale());
            endcase
            w = sb.clamp_size(sb.width_reg);
            h = sb.clamp_size(sb.height_reg);
            if (w == MAX_DIM || h == MAX_DIM) begin
                // the two border rows and columns at each corner
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                        load_pixel((i < 2) ? 8'(i) : 8'(252 + i),
                                   (j < 2) ? 8'(j) : 8'(252 + j));
            end else begin
                for (int r = 0; r < h; r++)
                    for (int c = 0; c < w; c++)
                        load_pixel(8'(r), 8'(c));
            end
            random_traffic(45);
            drain();
        end

        if (sb.errors == 0) begin
            $display("bilinear_image_resize_unit_test passed");
        end else begin
            $display("bilinear_image_resize_unit_test failed");
        end
        $finish;
    end
endmodule

// ----- bilinear_image_resize_unit.f -----
sv/bir_pkg.sv
sv/bilinear_image_resize_unit.sv
bench/bilinear_image_resize_unit_test.sv
